// ----- rtl/core/sae_pkg.sv -----
// ----------------------------------------------------------------------------
// sae_pkg
// Shared constants and types for the saturating audio echo block.
// ----------------------------------------------------------------------------
package sae_pkg;

   // delay store depth and history saturation point
   localparam int unsigned DELAY_DEPTH = 65536;
   localparam int unsigned HIST_MAX    = 65536;

   // fractional bits of the gain
   localparam int GAIN_FRAC = 12;

   // configuration port
   localparam int CSR_IW = 1;
   localparam int CSR_DW = 16;
   localparam logic [CSR_IW-1:0] CSR_DELAY = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_GAIN  = 1'd1;
   localparam logic [CSR_DW-1:0] DELAY_RESET = 16'd22050;
   localparam logic [CSR_DW-1:0] GAIN_RESET  = 16'd2048;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // one classified request handed from front to back
   typedef struct packed {
      logic [15:0] sample;
      logic [15:0] delayed;
      logic        echo_on;
   } echo_item_type;

endpackage

// ----- rtl/core/sae_front.sv -----
// ----------------------------------------------------------------------------
// sae_front
// Accepts requests, keeps the delay store and history, fetches the echo tap.
// ----------------------------------------------------------------------------
module sae_front #(
   parameter int unsigned DELAY_DEPTH = sae_pkg::DELAY_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [15:0]                   req_sample_in,
   input  logic                          req_start_of_clip,
   input  logic [15:0]                   delay_samples,
   input  logic [sae_pkg::QCOUNT_W-1:0]  queue_count,
   output logic                          item_valid,
   output sae_pkg::echo_item_type        item
);

   localparam int          AW   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int          PW   = AW + 1;
   localparam int unsigned LAST = DELAY_DEPTH - 1;

   logic [15:0]   mem [DELAY_DEPTH];

   logic [AW-1:0] wp_ff, wp_in;
   logic [16:0]   hist_ff, hist_in, hist_cur;
   logic          s1_valid_ff;
   logic [15:0]   x_ff, rd_ff;
   logic          zd_ff, on_ff;
   logic          accept, echo_on;
   logic [15:0]   dly;
   logic [PW-1:0] rp_sum;
   logic [AW-1:0] rp;

   // room for this request and the one in the fetch stage
   assign req_stall = (32'(queue_count) + 32'(s1_valid_ff)) >= 32'(sae_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   // clamp delay, classify, compute read slot, next write slot and history
   always_comb begin
      if (32'(delay_samples) > LAST) begin
         dly = 16'(LAST);
      end else begin
         dly = delay_samples;
      end
      hist_cur = req_start_of_clip ? 17'd0 : hist_ff;
      echo_on  = hist_cur >= {1'b0, dly};
      rp_sum   = PW'({1'b0, wp_ff}) + PW'(DELAY_DEPTH) - PW'(dly);
      if (rp_sum >= PW'(DELAY_DEPTH)) begin
         rp = AW'(rp_sum - PW'(DELAY_DEPTH));
      end else begin
         rp = AW'(rp_sum);
      end
      wp_in   = (32'(wp_ff) == LAST) ? '0 : wp_ff + 1'b1;
      hist_in = (32'(hist_cur) < sae_pkg::HIST_MAX) ? hist_cur + 17'd1 : hist_cur;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         hist_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            wp_ff   <= wp_in;
            hist_ff <= hist_in;
         end
      end
   end

   // delay store: write current sample, read echo tap
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_ff] <= req_sample_in;
         rd_ff      <= mem[rp];
         x_ff       <= req_sample_in;
         zd_ff      <= (dly == 16'd0);
         on_ff      <= echo_on;
      end
   end

   // zero delay taps the current sample
   assign item_valid    = s1_valid_ff;
   assign item.sample   = x_ff;
   assign item.delayed  = zd_ff ? x_ff : rd_ff;
   assign item.echo_on  = on_ff;

endmodule

// ----- rtl/core/sae_queue.sv -----
// ----------------------------------------------------------------------------
// sae_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module sae_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  sae_pkg::echo_item_type        push_item,
   input  logic                          pop,
   output logic                          pop_valid,
   output sae_pkg::echo_item_type        pop_item,
   output logic [sae_pkg::QCOUNT_W-1:0]  count
);

   sae_pkg::echo_item_type             entry_ff [sae_pkg::QUEUE_DEPTH];
   logic [sae_pkg::QPTR_W-1:0]         wr_ff, rd_ff;
   logic [sae_pkg::QCOUNT_W-1:0]       count_ff, count_in;

   assign pop_valid = count_ff != '0;
   assign pop_item  = entry_ff[rd_ff];
   assign count     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ff <= (32'(wr_ff) == sae_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (32'(rd_ff) == sae_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ff + 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/sae_back.sv -----
// ----------------------------------------------------------------------------
// sae_back
// Scales the echo tap, adds the sample, truncates and saturates.
// ----------------------------------------------------------------------------
module sae_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             echo_gain,
   input  logic                    in_valid,
   input  sae_pkg::echo_item_type  in_item,
   output logic                    in_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [15:0]             rsp_sample_out
);

   localparam int F = sae_pkg::GAIN_FRAC;

   logic                 advance;
   logic                 m_valid_ff, rsp_valid_ff;
   logic [15:0]          m_sample_ff, out_ff;
   logic signed [32:0]   prod, m_prod_ff;
   logic signed [16:0]   gain_s;
   logic signed [33:0]   acc;
   logic signed [21:0]   q;
   logic [15:0]          sat;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign in_pop  = advance && in_valid;

   // echo product
   assign gain_s = $signed({1'b0, echo_gain});
   assign prod   = in_item.echo_on ? $signed(in_item.delayed) * gain_s : 33'sd0;

   // sum, truncate toward zero, saturate
   always_comb begin
      acc = $signed({{(22 - 16){m_sample_ff[15]}}, m_sample_ff, {F{1'b0}}})
            + $signed({m_prod_ff[32], m_prod_ff});
      q   = $signed(acc[33:F]) + $signed({21'd0, acc[33] & (|acc[F-1:0])});
      if (q > 22'sd32767) begin
         sat = 16'h7FFF;
      end else if (q < -22'sd32768) begin
         sat = 16'h8000;
      end else begin
         sat = q[15:0];
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff   <= in_valid;
         rsp_valid_ff <= m_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (in_pop) begin
         m_sample_ff <= in_item.sample;
         m_prod_ff   <= prod;
      end
      if (advance && m_valid_ff) begin
         out_ff <= sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

endmodule

// ----- rtl/core/saturating_audio_echo.sv -----
// Path: an accepted request passes front fetch, queue, back product and output registers
// before its response is valid. Throughput: one request per cycle unless req_stall is high,
// with one delay store write and read each; back-pressure from the response side fills the
// queue before requests stall. Reset: synchronous; clears pointers, history, queue and
// valid flags, restores register defaults; the delay store is not cleared and need not be.
// ----------------------------------------------------------------------------
// saturating_audio_echo
// Feedforward comb echo on a 16-bit sample stream with Q4.12 gain and saturation.
// ----------------------------------------------------------------------------
module saturating_audio_echo #(
   parameter int unsigned DELAY_DEPTH = sae_pkg::DELAY_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [15:0]          req_sample_in,
   input  logic                        req_start_of_clip,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_sample_out,
   input  logic                        csr_wr_en,
   input  logic [sae_pkg::CSR_IW-1:0]  csr_index,
   input  logic [sae_pkg::CSR_DW-1:0]  csr_wdata
);

   logic [15:0]                   delay_ff, gain_ff;
   logic                          item_valid, q_valid, q_pop;
   sae_pkg::echo_item_type        item, q_item;
   logic [sae_pkg::QCOUNT_W-1:0]  q_count;
   logic [15:0]                   sample_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= sae_pkg::DELAY_RESET;
         gain_ff  <= sae_pkg::GAIN_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == sae_pkg::CSR_DELAY) begin
            delay_ff <= csr_wdata;
         end
         if (csr_index == sae_pkg::CSR_GAIN) begin
            gain_ff <= csr_wdata;
         end
      end
   end

   sae_front #(.DELAY_DEPTH(DELAY_DEPTH)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_in     (req_sample_in),
      .req_start_of_clip (req_start_of_clip),
      .delay_samples     (delay_ff),
      .queue_count       (q_count),
      .item_valid        (item_valid),
      .item              (item)
   );

   sae_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (item_valid),
      .push_item  (item),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .count      (q_count)
   );

   sae_back u_back (
      .clock          (clock),
      .reset          (reset),
      .echo_gain      (gain_ff),
      .in_valid       (q_valid),
      .in_item        (q_item),
      .in_pop         (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (sample_out)
   );

   assign rsp_sample_out = $signed(sample_out);

endmodule

// ----- rtl/core/sae_checker.sv -----
// ----------------------------------------------------------------------------
// sae_checker
// Port-level checks on request/response flow of the echo block.
// ----------------------------------------------------------------------------
module sae_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_sample_out
);

   logic [3:0] pending_ff;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // requests in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 4'(req_acc) - 4'(rsp_acc);
      end
   end

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its sample
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sample_out))
      else $error("response sample changed while stalled");

   // no response without a pending request
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response with no pending request");

   // an empty block takes requests
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 4'd0 |-> !req_stall)
      else $error("stall while empty");

   // in-flight bound: queue plus three stages
   a_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'd7)
      else $error("too many requests in flight");

endmodule

bind saturating_audio_echo sae_checker u_sae_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

// ----- bench/saturating_audio_echo_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// saturating_audio_echo_test
// Self-checking bench for the echo block: a short table of directed requests,
// then random clips with echo tails under changing delay and gain settings and
// changing idle patterns on both sides, each response checked against a table
// value or an in-bench echo predictor.
// ----------------------------------------------------------------------------
module saturating_audio_echo_test;

   localparam int RESULT_LATENCY = 4;
   localparam int TARGET_REQUESTS = 1050;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 5000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [15:0]        delay;
      logic [15:0]        gain;
      logic signed [15:0] sample;
      logic               start;
      logic               typed;
      logic signed [15:0] out;
   } bench_row_type;

   // directed requests; typed rows carry the expected sample, others use the predictor
   localparam bench_row_type DIRECTED [29] = '{
      // register defaults, no start mark yet: echo still off
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd32767, 1'b0, 1'b1, 16'sd32767},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd0, 1'b0, 1'b1, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd1, 1'b1, 1'b1, -16'sd1},
      // zero delay with the largest gain: the echo tap is the sample itself
      '{ROW_CONFIG, 16'd0, 16'hFFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd1, 1'b1, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd32767, 1'b0, 1'b1, 16'sd32767},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd1, 1'b0, 1'b0, 16'sd0},
      // zero gain: echo term vanishes even once history is long enough
      '{ROW_CONFIG, 16'd3, 16'd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd100, 1'b1, 1'b1, 16'sd100},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd200, 1'b0, 1'b1, -16'sd200},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd300, 1'b0, 1'b1, 16'sd300},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd32767, 1'b0, 1'b1, 16'sd32767},
      // unity gain: saturation both ways, then a start mark mid-clip
      '{ROW_CONFIG, 16'd2, 16'd4096, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd20000, 1'b1, 1'b1, 16'sd20000},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd20000, 1'b0, 1'b1, -16'sd20000},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd20000, 1'b0, 1'b1, 16'sd32767},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd20000, 1'b0, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd3, 1'b1, 1'b1, -16'sd3},
      // longest delay: no echo within a short clip
      '{ROW_CONFIG, 16'hFFFF, 16'hFFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd1234, 1'b0, 1'b1, 16'sd1234},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd1, 1'b1, 1'b1, -16'sd1},
      // half gain, one sample delay: truncation toward zero on both signs
      '{ROW_CONFIG, 16'd1, 16'd2048, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd3, 1'b1, 1'b1, -16'sd3},
      '{ROW_SAMPLE, 16'd0, 16'd0, -16'sd1, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd1, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 16'd0, 16'd0, 16'sh8000, 1'b0, 1'b0, 16'sd0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   wire                        req_stall;
   logic signed [15:0]         req_sample_in = '0;
   logic                       req_start_of_clip = 1'b0;
   wire                        rsp_valid;
   logic                       rsp_stall = 1'b0;
   wire signed [15:0]          rsp_sample_out;
   logic                       csr_wr_en = 1'b0;
   logic [sae_pkg::CSR_IW-1:0] csr_index = sae_pkg::CSR_DELAY;
   logic [sae_pkg::CSR_DW-1:0] csr_wdata = '0;

   // predictor state: sample history, write slot, clip length, register copies
   logic [15:0]          echo_history [0:sae_pkg::DELAY_DEPTH-1];
   int unsigned          history_slot = 0;
   int unsigned          clip_samples_seen = 0;
   logic [15:0]          delay_setting = sae_pkg::DELAY_RESET;
   logic [15:0]          gain_setting = sae_pkg::GAIN_RESET;

   logic signed [15:0]   expected_samples [$];
   logic signed [15:0]   oldest_sample;
   int                   error_count = 0;
   int                   requests_sent = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   holds_asked = 0;
   int                   holds_given = 0;
   int                   hold_left = 0;

   saturating_audio_echo dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_in     (req_sample_in),
      .req_start_of_clip (req_start_of_clip),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_out    (rsp_sample_out),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // echo of one request: store, add the scaled delayed sample, truncate, saturate
   function automatic logic signed [15:0] echo_predict(input logic signed [15:0] sample,
                                                       input logic start);
      int          current;
      int unsigned lag;
      int unsigned read_slot;
      longint      sum;
      longint      quotient;
      current = sample;
      if (start) begin
         clip_samples_seen = 0;
      end
      lag = delay_setting;
      if (lag > sae_pkg::DELAY_DEPTH - 1) begin
         lag = sae_pkg::DELAY_DEPTH - 1;
      end
      echo_history[history_slot] = sample;
      sum = longint'(current) * (longint'(1) << sae_pkg::GAIN_FRAC);
      if (clip_samples_seen >= lag) begin
         read_slot = (history_slot + sae_pkg::DELAY_DEPTH - lag) % sae_pkg::DELAY_DEPTH;
         sum += longint'($signed(echo_history[read_slot])) * longint'(gain_setting);
      end
      // signed division truncates toward zero
      quotient = sum / (longint'(1) << sae_pkg::GAIN_FRAC);
      if (quotient > 32767) begin
         quotient = 32767;
      end else if (quotient < -32768) begin
         quotient = -32768;
      end
      history_slot = (history_slot + 1) % sae_pkg::DELAY_DEPTH;
      if (clip_samples_seen < sae_pkg::HIST_MAX) begin
         clip_samples_seen++;
      end
      return quotient[15:0];
   endfunction

   task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                  input logic signed [15:0] want);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      end
      error_count++;
   endtask

   // offer one request after random idle cycles; returns at the accepting edge
   task automatic push_request(input logic signed [15:0] sample, input logic start,
                               input logic typed, input logic signed [15:0] typed_out);
      logic               taken;
      logic signed [15:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= sample;
      req_start_of_clip <= start;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predicted = echo_predict(sample, start);
      expected_samples.push_back(typed ? typed_out : predicted);
      requests_sent++;
   endtask

   // settings change only once every response is back and the pipe is empty
   task automatic program_echo(input logic [15:0] delay, input logic [15:0] gain);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * RESULT_LATENCY) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sae_pkg::CSR_DELAY;
      csr_wdata <= delay;
      @(posedge clock);
      csr_index <= sae_pkg::CSR_GAIN;
      csr_wdata <= gain;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      delay_setting = delay;
      gain_setting = gain;
   endtask

   // response side: random stalls, plus a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_given != holds_asked) begin
         holds_given++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // compare each accepted response with the oldest expected sample
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_sample_out, '0);
         end else begin
            oldest_sample = expected_samples.pop_front();
            if (rsp_sample_out !== oldest_sample) begin
               report_mismatch("sample_out", rsp_sample_out, oldest_sample);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      bench_row_type      row;
      logic [15:0]        delay;
      logic [15:0]        gain;
      logic signed [15:0] sample;
      logic               start;
      int                 phase;
      int                 clip_len;
      int                 drain_cycles;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < $size(DIRECTED); i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CONFIG) begin
            program_echo(row.delay, row.gain);
         end else begin
            push_request(row.sample, row.start, row.typed, row.out);
         end
      end

      // random clips, each phase with its own settings and idle pattern
      phase = 0;
      while (requests_sent < TARGET_REQUESTS) begin
         case ($urandom_range(19))
            0: begin
               delay = 16'hFFFF;
            end
            1: begin
               delay = 16'($urandom);
            end
            2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
               delay = 16'($urandom_range(0, 8));
            end
            default: begin
               delay = 16'($urandom_range(9, 64));
            end
         endcase
         case ($urandom_range(9))
            0: begin
               gain = 16'h0000;
            end
            1: begin
               gain = 16'hFFFF;
            end
            2: begin
               gain = 16'h1000;
            end
            3: begin
               gain = 16'($urandom);
            end
            default: begin
               gain = 16'($urandom_range(0, 8191));
            end
         endcase
         program_echo(delay, gain);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 59;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 59;
            end
            default: begin
               send_idle_pct = 36;
               stall_pct = 36;
            end
         endcase
         // long response hold-off while requests keep coming, to back up the input
         if (phase == 0) begin
            holds_asked++;
         end
         repeat ($urandom_range(1, 3)) begin
            // the first phase sends enough requests to fill the block during the hold
            clip_len = (phase == 0) ? $urandom_range(30, 90) : $urandom_range(1, 90);
            for (int k = 0; k < clip_len; k++) begin
               if (k == 0) begin
                  start = ($urandom_range(9) != 0);
               end else begin
                  start = ($urandom_range(29) == 0);
               end
               case ($urandom_range(7))
                  0: begin
                     sample = 16'sh7FFF;
                  end
                  1: begin
                     sample = 16'sh8000;
                  end
                  2: begin
                     sample = 16'($urandom_range(0, 64) - 32);
                  end
                  default: begin
                     sample = 16'($urandom);
                  end
               endcase
               push_request(sample, start, 1'b0, '0);
            end
            // echo tail: zero samples for the length of the delay, when it is at most 64
            if (delay <= 64) begin
               repeat (delay) push_request('0, 1'b0, 1'b0, '0);
            end
         end
         phase++;
      end

      // wait out the remaining responses
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (expected_samples.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (expected_samples.size() != 0) begin
         report_mismatch("responses never arrived, count", 16'(expected_samples.size()), '0);
      end
      repeat (2 * RESULT_LATENCY) @(posedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/sae_pkg.sv
rtl/core/sae_front.sv
rtl/core/sae_queue.sv
rtl/core/sae_back.sv
rtl/core/saturating_audio_echo.sv
rtl/core/sae_checker.sv
bench/saturating_audio_echo_test.sv
